/* rtl/rau_pkg.sv */
// ----------------------------------------------------------------------------
// rau_pkg
// shared types and operation codes of the rational arithmetic unit
// ----------------------------------------------------------------------------
package rau_pkg;

    // operation codes
    localparam logic [3:0] OP_ADD = 4'd0;
    localparam logic [3:0] OP_SUB = 4'd1;
    localparam logic [3:0] OP_MUL = 4'd2;
    localparam logic [3:0] OP_DIV = 4'd3;
    localparam logic [3:0] OP_GT  = 4'd4;
    localparam logic [3:0] OP_LT  = 4'd5;
    localparam logic [3:0] OP_GE  = 4'd6;
    localparam logic [3:0] OP_LE  = 4'd7;
    localparam logic [3:0] OP_EQ  = 4'd8;
    localparam logic [3:0] OP_NE  = 4'd9;

    // output field widths
    localparam int NumOutWidth = 32;
    localparam int DenOutWidth = 31;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL_LEFT,
        ST_MUL_RIGHT,
        ST_MUL_NUM,
        ST_MUL_DEN,
        ST_SETUP,
        ST_CHECK,
        ST_GCD,
        ST_DIV_NUM,
        ST_DIV_DEN,
        ST_FINISH
    } t_rau_state;

    typedef enum logic [1:0] {
        GCD_IDLE,
        GCD_REDUCE,
        GCD_SCALE
    } t_gcd_state;

    typedef enum logic [1:0] {
        DIV_IDLE,
        DIV_RUN,
        DIV_DONE
    } t_div_state;

endpackage

/* rtl/rau_gcd.sv */
// ----------------------------------------------------------------------------
// rau_gcd
// binary gcd of two nonzero unsigned values, one shift or subtract per cycle
// ----------------------------------------------------------------------------
module rau_gcd #(
    parameter int DW = 32
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [DW-1:0] i_x,
    input  logic [DW-1:0] i_y,
    output logic          o_done,
    output logic [DW-1:0] o_gcd
);

    localparam int KW = $clog2(DW);

    rau_pkg::t_gcd_state r_state, n_state;
    logic [DW-1:0] r_x, r_y;
    logic [KW-1:0] r_k;
    logic          w_zero;

    assign w_zero = (r_x == '0) || (r_y == '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= rau_pkg::GCD_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            rau_pkg::GCD_IDLE: begin
                if (i_start) n_state = rau_pkg::GCD_REDUCE;
            end
            rau_pkg::GCD_REDUCE: begin
                if (w_zero) n_state = rau_pkg::GCD_SCALE;
            end
            rau_pkg::GCD_SCALE: begin
                if (r_k == '0) n_state = rau_pkg::GCD_IDLE;
            end
            default: n_state = rau_pkg::GCD_IDLE;
        endcase
    end

    always_comb begin
        o_done = (r_state == rau_pkg::GCD_SCALE) && (r_k == '0);
        o_gcd  = r_x;
    end

    // datapath
    always_ff @(posedge i_clk) begin
        case (r_state)
            rau_pkg::GCD_IDLE: begin
                r_x <= i_x;
                r_y <= i_y;
                r_k <= '0;
            end
            rau_pkg::GCD_REDUCE: begin
                if (w_zero) begin
                    r_x <= r_x | r_y;
                end else if (!r_x[0] && !r_y[0]) begin
                    r_x <= r_x >> 1;
                    r_y <= r_y >> 1;
                    r_k <= r_k + 1'b1;
                end else if (!r_x[0]) begin
                    r_x <= r_x >> 1;
                end else if (!r_y[0]) begin
                    r_y <= r_y >> 1;
                end else if (r_x >= r_y) begin
                    r_x <= r_x - r_y;
                end else begin
                    r_y <= r_y - r_x;
                end
            end
            rau_pkg::GCD_SCALE: begin
                if (r_k != '0) begin
                    r_x <= r_x << 1;
                    r_k <= r_k - 1'b1;
                end
            end
            default: begin
                r_k <= '0;
            end
        endcase
    end

endmodule

/* rtl/rau_div.sv */
// ----------------------------------------------------------------------------
// rau_div
// restoring unsigned divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module rau_div #(
    parameter int DW = 32
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [DW-1:0] i_dividend,
    input  logic [DW-1:0] i_divisor,
    output logic          o_done,
    output logic [DW-1:0] o_quot
);

    localparam int CW = $clog2(DW);

    rau_pkg::t_div_state r_state, n_state;
    logic [DW-1:0] r_rem, r_quot, r_divisor;
    logic [CW-1:0] r_cnt;
    logic [DW:0]   w_trial;
    logic          w_fit;
    logic          w_last;

    assign w_trial = {r_rem, r_quot[DW-1]};
    assign w_fit   = w_trial >= {1'b0, r_divisor};
    assign w_last  = r_cnt == CW'(DW - 1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= rau_pkg::DIV_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            rau_pkg::DIV_IDLE: begin
                if (i_start) n_state = rau_pkg::DIV_RUN;
            end
            rau_pkg::DIV_RUN: begin
                if (w_last) n_state = rau_pkg::DIV_DONE;
            end
            // a start in the done cycle chains straight into the next division
            rau_pkg::DIV_DONE: n_state = i_start ? rau_pkg::DIV_RUN : rau_pkg::DIV_IDLE;
            default:           n_state = rau_pkg::DIV_IDLE;
        endcase
    end

    always_comb begin
        o_done = r_state == rau_pkg::DIV_DONE;
        o_quot = r_quot;
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            rau_pkg::DIV_IDLE, rau_pkg::DIV_DONE: begin
                r_rem     <= '0;
                r_quot    <= i_dividend;
                r_divisor <= i_divisor;
                r_cnt     <= '0;
            end
            rau_pkg::DIV_RUN: begin
                r_rem  <= w_fit ? DW'(w_trial - {1'b0, r_divisor}) : w_trial[DW-1:0];
                r_quot <= {r_quot[DW-2:0], w_fit};
                r_cnt  <= r_cnt + 1'b1;
            end
            default: begin
                r_cnt <= '0;
            end
        endcase
    end

endmodule

/* rtl/rational_arithmetic_unit.sv */
// ----------------------------------------------------------------------------
// rational_arithmetic_unit
// add, subtract, multiply, divide or compare two fractions, reduced by gcd
// ----------------------------------------------------------------------------
// usage
//   command port: raise start with the operation and both fractions; the
//   beat is taken when start is high and busy is low. busy stays high until
//   the result beat has been shown.
//   result port: o_done is high for exactly one cycle with the reduced
//   numerator, positive denominator, compare flag and divide-by-zero flag.
//   the receiver cannot stall; the result must be captured on that cycle.
// sequence
//   four products go through one shared multiplier, one per cycle. the
//   reduction then runs a binary gcd (one shift or subtract per cycle) and
//   two restoring divisions, numerator then denominator. comparisons,
//   unused codes, zero results and division by zero skip the gcd and the
//   divisions. one command is worked on at a time; a new one is taken only
//   after the result of the last one has been shown.
// reset
//   synchronous active-low reset returns the sequencer and both units to
//   idle; no result is shown. the datapath and result registers have no reset.
// ----------------------------------------------------------------------------
module rational_arithmetic_unit #(
    parameter int OPERAND_WIDTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     start,
    output logic                     busy,
    input  logic [3:0]               i_operation,
    input  logic signed [OPERAND_WIDTH-1:0] i_a_numerator,
    input  logic signed [OPERAND_WIDTH-1:0] i_a_denominator,
    input  logic signed [OPERAND_WIDTH-1:0] i_b_numerator,
    input  logic signed [OPERAND_WIDTH-1:0] i_b_denominator,
    output logic                     o_done,
    output logic signed [31:0]       o_result_numerator,
    output logic [30:0]              o_result_denominator,
    output logic                     o_compare_true,
    output logic                     o_divide_by_zero
);

    localparam int W  = OPERAND_WIDTH;
    localparam int DW = 2 * OPERAND_WIDTH;   // product and magnitude width
    localparam int PW = 2 * OPERAND_WIDTH + 2; // full multiplier result

    rau_pkg::t_rau_state r_state, n_state;

    // captured command
    logic [3:0]          r_op;
    logic signed [W-1:0] r_an, r_ad, r_bn, r_bd;

    // products and working values
    logic signed [DW-1:0] r_left, r_right, r_nprod;
    logic [DW-1:0]        r_den, r_mag, r_g, r_qnum;
    logic                 r_neg;

    // result registers
    logic signed [31:0] r_res_num;
    logic [30:0]        r_res_den;
    logic               r_cmp, r_dz;

    // shared multiplier
    logic signed [W:0]    w_mul_a, w_mul_b;
    logic signed [PW-1:0] w_prod;
    logic signed [DW-1:0] w_prod_t;

    // units
    logic          w_gcd_start, w_gcd_done;
    logic [DW-1:0] w_gcd;
    logic          w_div_start, w_div_done;
    logic [DW-1:0] w_div_dividend, w_div_divisor, w_quot;

    logic                 w_arith, w_div_zero, w_cmp;
    logic signed [DW-1:0] w_num;
    logic signed [DW-1:0] w_qsigned;
    logic [DW+31:0]       w_num_ext, w_den_ext;

    // denominators of zero or less read as one
    function automatic logic signed [W-1:0] clamp_den(input logic signed [W-1:0] d);
        logic signed [W-1:0] one;
        one = W'(1);
        return (d[W-1] || d == '0) ? one : d;
    endfunction

    // ------------------------------------------------------------------
    // sequencer
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= rau_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign w_arith = (r_op == rau_pkg::OP_ADD) || (r_op == rau_pkg::OP_SUB) ||
                     (r_op == rau_pkg::OP_MUL) || (r_op == rau_pkg::OP_DIV);
    assign w_div_zero = (r_op == rau_pkg::OP_DIV) && (r_bn == '0);

    always_comb begin
        n_state = r_state;
        case (r_state)
            rau_pkg::ST_IDLE:      if (start) n_state = rau_pkg::ST_MUL_LEFT;
            rau_pkg::ST_MUL_LEFT:  n_state = rau_pkg::ST_MUL_RIGHT;
            rau_pkg::ST_MUL_RIGHT: n_state = rau_pkg::ST_MUL_NUM;
            rau_pkg::ST_MUL_NUM:   n_state = rau_pkg::ST_MUL_DEN;
            rau_pkg::ST_MUL_DEN:   n_state = rau_pkg::ST_SETUP;
            rau_pkg::ST_SETUP:     n_state = rau_pkg::ST_CHECK;
            rau_pkg::ST_CHECK: begin
                if (w_arith && !w_div_zero && r_mag != '0) begin
                    n_state = rau_pkg::ST_GCD;
                end else begin
                    n_state = rau_pkg::ST_FINISH;
                end
            end
            rau_pkg::ST_GCD:     if (w_gcd_done) n_state = rau_pkg::ST_DIV_NUM;
            rau_pkg::ST_DIV_NUM: if (w_div_done) n_state = rau_pkg::ST_DIV_DEN;
            rau_pkg::ST_DIV_DEN: if (w_div_done) n_state = rau_pkg::ST_FINISH;
            rau_pkg::ST_FINISH:  n_state = rau_pkg::ST_IDLE;
            default:             n_state = rau_pkg::ST_IDLE;
        endcase
    end

    // control outputs
    always_comb begin
        busy        = r_state != rau_pkg::ST_IDLE;
        o_done      = r_state == rau_pkg::ST_FINISH;
        w_gcd_start = (r_state == rau_pkg::ST_CHECK) && w_arith && !w_div_zero &&
                      (r_mag != '0);
        w_div_start = ((r_state == rau_pkg::ST_GCD) && w_gcd_done) ||
                      ((r_state == rau_pkg::ST_DIV_NUM) && w_div_done);
    end

    assign o_result_numerator   = r_res_num;
    assign o_result_denominator = r_res_den;
    assign o_compare_true       = r_cmp;
    assign o_divide_by_zero     = r_dz;

    // ------------------------------------------------------------------
    // shared multiplier: one product per cycle
    // ------------------------------------------------------------------
    always_comb begin
        w_mul_a = {r_ad[W-1], r_ad};
        w_mul_b = {r_bd[W-1], r_bd};
        case (r_state)
            rau_pkg::ST_MUL_LEFT: begin
                w_mul_a = {r_an[W-1], r_an};
                w_mul_b = {r_bd[W-1], r_bd};
            end
            rau_pkg::ST_MUL_RIGHT: begin
                w_mul_a = {r_ad[W-1], r_ad};
                w_mul_b = {r_bn[W-1], r_bn};
            end
            rau_pkg::ST_MUL_NUM: begin
                w_mul_a = {r_an[W-1], r_an};
                w_mul_b = {r_bn[W-1], r_bn};
            end
            rau_pkg::ST_MUL_DEN: begin
                // a divide uses the magnitude of the divisor numerator
                w_mul_a = {r_ad[W-1], r_ad};
                if (r_op == rau_pkg::OP_DIV && r_bn[W-1]) begin
                    w_mul_b = -{r_bn[W-1], r_bn};
                end else if (r_op == rau_pkg::OP_DIV) begin
                    w_mul_b = {r_bn[W-1], r_bn};
                end else begin
                    w_mul_b = {r_bd[W-1], r_bd};
                end
            end
            default: begin
                w_mul_a = {r_ad[W-1], r_ad};
            end
        endcase
    end

    assign w_prod   = w_mul_a * w_mul_b;
    assign w_prod_t = w_prod[DW-1:0];

    // numerator before reduction, per operation
    always_comb begin
        case (r_op)
            rau_pkg::OP_ADD: w_num = r_left + r_right;
            rau_pkg::OP_SUB: w_num = r_left - r_right;
            rau_pkg::OP_MUL: w_num = r_nprod;
            rau_pkg::OP_DIV: w_num = r_bn[W-1] ? -r_left : r_left;
            default:         w_num = '0;
        endcase
    end

    // comparison of the cross products
    always_comb begin
        case (r_op)
            rau_pkg::OP_GT: w_cmp = r_left >  r_right;
            rau_pkg::OP_LT: w_cmp = r_left <  r_right;
            rau_pkg::OP_GE: w_cmp = r_left >= r_right;
            rau_pkg::OP_LE: w_cmp = r_left <= r_right;
            rau_pkg::OP_EQ: w_cmp = r_left == r_right;
            rau_pkg::OP_NE: w_cmp = r_left != r_right;
            default:        w_cmp = 1'b0;
        endcase
    end

    // divider operands: numerator magnitude first, then denominator
    assign w_div_dividend = (r_state == rau_pkg::ST_GCD) ? r_mag : r_den;
    assign w_div_divisor  = (r_state == rau_pkg::ST_GCD) ? w_gcd : r_g;

    // final sign and wrap to output field widths
    assign w_qsigned = r_neg ? -$signed(r_qnum) : $signed(r_qnum);
    assign w_num_ext = {{32{w_qsigned[DW-1]}}, w_qsigned};
    assign w_den_ext = {32'b0, w_quot};

    // ------------------------------------------------------------------
    // datapath
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        case (r_state)
            rau_pkg::ST_IDLE: begin
                if (start) begin
                    r_op <= i_operation;
                    r_an <= i_a_numerator;
                    r_ad <= clamp_den(i_a_denominator);
                    r_bn <= i_b_numerator;
                    r_bd <= clamp_den(i_b_denominator);
                end
            end
            rau_pkg::ST_MUL_LEFT:  r_left  <= w_prod_t;
            rau_pkg::ST_MUL_RIGHT: r_right <= w_prod_t;
            rau_pkg::ST_MUL_NUM:   r_nprod <= w_prod_t;
            rau_pkg::ST_MUL_DEN:   r_den   <= w_prod_t;
            rau_pkg::ST_SETUP: begin
                r_neg <= w_num[DW-1];
                r_mag <= w_num[DW-1] ? DW'(-w_num) : DW'(w_num);
            end
            rau_pkg::ST_CHECK: begin
                // defaults cover comparisons, unused codes, zero results and division by zero
                r_res_num <= '0;
                r_res_den <= 31'd1;
                r_cmp     <= w_cmp;
                r_dz      <= w_div_zero;
            end
            rau_pkg::ST_GCD: begin
                if (w_gcd_done) r_g <= w_gcd;
            end
            rau_pkg::ST_DIV_NUM: begin
                if (w_div_done) r_qnum <= w_quot;
            end
            rau_pkg::ST_DIV_DEN: begin
                if (w_div_done) begin
                    r_res_num <= w_num_ext[rau_pkg::NumOutWidth-1:0];
                    r_res_den <= w_den_ext[rau_pkg::DenOutWidth-1:0];
                end
            end
            default: begin
                r_neg <= r_neg;
            end
        endcase
    end

    rau_gcd #(
        .DW(DW)
    ) u_gcd (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_gcd_start),
        .i_x     (r_mag),
        .i_y     (r_den),
        .o_done  (w_gcd_done),
        .o_gcd   (w_gcd)
    );

    rau_div #(
        .DW(DW)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_div_dividend),
        .i_divisor  (w_div_divisor),
        .o_done     (w_div_done),
        .o_quot     (w_quot)
    );

endmodule
